// ===== src/kmh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmh_pkg
// Shared types for the k-way merge heap: sequencer states and heap entry.
// ----------------------------------------------------------------------------
package kmh_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_POP_CHK,
    ST_POP_ROOT,
    ST_POP_LAST,
    ST_SIFT_L,
    ST_SIFT_R,
    ST_SIFT_CMP
  } kmh_state_t;

  typedef struct packed {
    logic [31:0] value;
    logic [6:0]  run;
  } kmh_entry_t;

  // Ordering key: signed value then lower run index.
  function automatic logic [38:0] kmh_key(input kmh_entry_t e);
    kmh_key = {~e.value[31], e.value[30:0], e.run};
  endfunction

endpackage

// ===== src/kmh_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmh_in_if / kmh_out_if
// Valid/ready channels for run beats and merged result beats.
// ----------------------------------------------------------------------------
interface kmh_in_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] value;
  logic [6:0]        run_id;
  logic              exhausted;
  modport source (output valid, value, run_id, exhausted, input ready);
  modport sink (input valid, value, run_id, exhausted, output ready);
endinterface

interface kmh_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] min_value;
  logic [6:0]        refill_run;
  logic              done_res;
  modport source (output valid, min_value, refill_run, done_res, input ready);
  modport sink (input valid, min_value, refill_run, done_res, output ready);
endinterface

// ===== src/kway_merge_heap.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kway_merge_heap
// Min-heap k-way merge: each beat inserts a run's next value (unless the run is
//   exhausted or the heap is full), then pops the min once the fill is complete.
// Steps: the insert moves the hole up, reading one parent per level; the pop
//   fetches the root and the last entry, then sifts down, reading the left and
//   right child per level. A done beat is emitted when the heap is empty.
// Throughput: one beat in flight; the next beat is taken once the sequencer
//   is back in idle. A waiting result holds the pop in ST_POP_CHK, and so
//   the input too.
// Reset: rst (synchronous) clears heap_size and fill_count and loads a run count
//   of 1; the heap RAM is not cleared.
// ----------------------------------------------------------------------------
module kway_merge_heap import kmh_pkg::*; #(
  parameter int MAX_RUNS = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  kmh_in_if.sink     in_ch,
  kmh_out_if.source  out_ch
);

  localparam int AW = $clog2(MAX_RUNS);
  localparam int SW = AW + 1;

  // Heap storage: one synchronous RAM, one read and one write per cycle.
  kmh_entry_t mem [MAX_RUNS];
  kmh_entry_t rd_data;
  logic       mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  kmh_entry_t mem_wdata;

  kmh_state_t state, state_next;
  logic [7:0]  runs_cfg;
  logic [SW-1:0] heap_size, fill_count;
  logic [AW-1:0] idx;        // hole position
  kmh_entry_t  cur;          // entry being placed
  kmh_entry_t  lchild;       // left child held while right is read
  logic        do_pop;
  kmh_entry_t  res;
  logic        res_done;
  logic        out_valid;
  logic        emit;
  logic        pick_right;
  logic        sift_stop;
  kmh_entry_t  best;
  logic [AW-1:0] best_idx;
  logic [SW-1:0] eff_runs;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data <= mem[mem_raddr];
  end

  // Effective run count clipped to [1, MAX_RUNS].
  always_comb begin
    if (runs_cfg == 8'd0) eff_runs = SW'(1);
    else if (32'(runs_cfg) > MAX_RUNS) eff_runs = SW'(MAX_RUNS);
    else eff_runs = SW'(runs_cfg);
  end

  wire in_fire  = in_ch.valid && in_ch.ready;
  // Result register still occupied at this edge.
  wire out_busy = out_valid && !out_ch.ready;
  // Drop the insert when the run is exhausted or the heap is full.
  wire ins_go   = !in_ch.exhausted && (heap_size < SW'(MAX_RUNS));

  assign in_ch.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) runs_cfg <= 8'd1;
    else if (cfg_we) runs_cfg <= cfg_wdata;
  end

  // Parent and children of the hole.
  wire [AW-1:0] parent     = (idx - AW'(1)) >> 1;
  wire [SW:0]   lc_idx     = {1'b0, idx, 1'b1};
  wire [SW:0]   rc_idx     = lc_idx + (SW+1)'(1);
  wire          lc_out     = lc_idx >= {1'b0, heap_size};
  wire          have_right = rc_idx < {1'b0, heap_size};
  wire          parent_gt  = kmh_key(rd_data) > kmh_key(cur);

  // Sift compare: right child wins only when strictly smaller.
  always_comb begin
    pick_right = have_right && (kmh_key(rd_data) < kmh_key(lchild));
    best       = pick_right ? rd_data : lchild;
    best_idx   = pick_right ? rc_idx[AW-1:0] : lc_idx[AW-1:0];
    sift_stop  = kmh_key(cur) <= kmh_key(best);
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) state_next = ins_go ? ST_INS_RD : ST_POP_CHK;
      end
      ST_INS_RD:   state_next = (idx == '0) ? ST_POP_CHK : ST_INS_CMP;
      ST_INS_CMP:  state_next = parent_gt ? ST_INS_RD : ST_POP_CHK;
      ST_POP_CHK: begin
        // Hold the pop until the result register is free.
        if (!do_pop) state_next = ST_IDLE;
        else if (!out_busy) state_next = (heap_size == '0) ? ST_IDLE : ST_POP_ROOT;
      end
      ST_POP_ROOT: state_next = (heap_size == SW'(1)) ? ST_IDLE : ST_POP_LAST;
      ST_POP_LAST: state_next = ST_SIFT_L;
      ST_SIFT_L:   state_next = lc_out ? ST_IDLE : ST_SIFT_R;
      ST_SIFT_R:   state_next = ST_SIFT_CMP;
      ST_SIFT_CMP: state_next = sift_stop ? ST_IDLE : ST_SIFT_L;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Outputs: RAM address and write control, result strobe.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = cur;
    mem_raddr = parent;
    emit      = 1'b0;
    case (state)
      ST_INS_RD: begin
        // At the root: place the new entry.
        if (idx == '0) mem_we = 1'b1;
      end
      ST_INS_CMP: begin
        // Move the parent down into the hole, or place the new entry.
        mem_we = 1'b1;
        if (parent_gt) mem_wdata = rd_data;
      end
      ST_POP_CHK: begin
        mem_raddr = '0;
        emit      = do_pop && !out_busy && (heap_size == '0);
      end
      ST_POP_ROOT: begin
        mem_raddr = AW'(heap_size - SW'(1));
        emit      = (heap_size == SW'(1));
      end
      ST_SIFT_L: begin
        mem_raddr = lc_idx[AW-1:0];
        if (lc_out) begin
          mem_we = 1'b1;
          emit   = 1'b1;
        end
      end
      ST_SIFT_R:   mem_raddr = rc_idx[AW-1:0];
      ST_SIFT_CMP: begin
        // Place the last entry, or move the smaller child up into the hole.
        mem_we = 1'b1;
        if (sift_stop) emit = 1'b1;
        else mem_wdata = best;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      heap_size  <= '0;
      fill_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
      if (in_fire) begin
        if (fill_count < eff_runs) fill_count <= fill_count + SW'(1);
        if (ins_go) heap_size <= heap_size + SW'(1);
      end
      if (state == ST_POP_ROOT) heap_size <= heap_size - SW'(1);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          cur.value <= in_ch.value;
          cur.run   <= in_ch.run_id;
          idx       <= AW'(heap_size);
          // Pop unless this beat leaves the fill still incomplete.
          do_pop    <= (fill_count + SW'(1)) >= eff_runs;
        end
      end
      ST_INS_CMP: begin
        if (parent_gt) idx <= parent;
      end
      ST_POP_CHK: begin
        if (do_pop && !out_busy && heap_size == '0) begin
          res      <= '0;
          res_done <= 1'b1;
        end
      end
      ST_POP_ROOT: begin
        res      <= rd_data;
        res_done <= 1'b0;
      end
      ST_POP_LAST: begin
        // Sift the last entry down from the root.
        cur <= rd_data;
        idx <= '0;
      end
      ST_SIFT_R:   lchild <= rd_data;
      ST_SIFT_CMP: begin
        if (!sift_stop) idx <= best_idx;
      end
      default: ;
    endcase
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.min_value  = res.value;
  assign out_ch.refill_run = res.run;
  assign out_ch.done_res   = res_done;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> state == ST_IDLE) else $error("beat taken while busy");
  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    heap_size <= SW'(MAX_RUNS)) else $error("heap overflow");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= SW'(MAX_RUNS)) else $error("fill overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid && $stable(res) && $stable(res_done))
    else $error("result changed while stalled");

endmodule

// ===== verif/kway_merge_heap_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kway_merge_heap_tb
// Self-checking bench for the k-way merge heap. A local min-heap predictor
// tracks fill and merge behavior for every accepted run beat. Stimulus is a
// directed pass over value extremes, ties, exhaustion and repeated done, then
// mostly well-formed merge traffic that answers for the run named by the last
// result. Some random noise beats are mixed in. Both sides idle at random.
// ----------------------------------------------------------------------------
module kway_merge_heap_tb;

  localparam int HEAP_DEPTH = 128;
  localparam int SETTLE_CYCLES = 120;

  typedef struct {
    logic signed [31:0] value;
    logic [6:0]         run;
    logic               ex;
  } run_beat_t;

  typedef struct {
    logic signed [31:0] min_value;
    logic [6:0]         refill_run;
    logic               done_res;
  } merge_res_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  kmh_in_if  in_ch ();
  kmh_out_if out_ch ();

  kway_merge_heap #(.MAX_RUNS(HEAP_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Predictor state: mirror of the heap, fill progress and run count.
  logic [31:0] heap_val [HEAP_DEPTH];
  logic [6:0]  heap_run [HEAP_DEPTH];
  int unsigned heap_len;
  int unsigned fill_seen;
  logic [7:0]  runs_reg;

  // Generator memory: last value sent per run and the run owed next.
  logic signed [31:0] run_tail [HEAP_DEPTH];
  logic [6:0] owed_run;
  bit         owed_valid;

  merge_res_t pending_q[$];
  int unsigned mismatches;
  int unsigned beats_sent;
  int unsigned results_seen;
  int unsigned dones_seen;

  // Receiver controls.
  logic hold_on;
  int unsigned stall_pct;
  int unsigned rx_cycle;

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic logic [38:0] heap_order(logic [31:0] v, logic [6:0] r);
    // Flip the sign bit so signed order becomes unsigned order; run breaks ties.
    return {v ^ 32'h8000_0000, r};
  endfunction

  function automatic int unsigned active_runs();
    if (runs_reg == 8'd0) return 1;
    if (runs_reg > HEAP_DEPTH) return HEAP_DEPTH;
    return runs_reg;
  endfunction

  function automatic void heap_push(logic [31:0] v, logic [6:0] r);
    int unsigned i;
    int unsigned p;
    logic [38:0] k;
    k = heap_order(v, r);
    if (heap_len >= HEAP_DEPTH) return;  // drop on full heap
    i = heap_len;
    heap_len++;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (heap_order(heap_val[p], heap_run[p]) <= k) break;
      heap_val[i] = heap_val[p];
      heap_run[i] = heap_run[p];
      i = p;
    end
    heap_val[i] = v;
    heap_run[i] = r;
  endfunction

  function automatic void heap_take(output logic [31:0] v, output logic [6:0] r);
    int unsigned i;
    int unsigned c;
    logic [31:0] lv;
    logic [6:0]  lr;
    logic [38:0] lk;
    logic [38:0] ck;
    logic [38:0] rk;
    i = 0;
    v = heap_val[0];
    r = heap_run[0];
    heap_len--;
    if (heap_len == 0) return;
    lv = heap_val[heap_len];
    lr = heap_run[heap_len];
    lk = heap_order(lv, lr);
    forever begin
      c = 2 * i + 1;
      if (c >= heap_len) break;
      ck = heap_order(heap_val[c], heap_run[c]);
      if (c + 1 < heap_len) begin
        rk = heap_order(heap_val[c + 1], heap_run[c + 1]);
        if (rk < ck) begin
          c++;
          ck = rk;
        end
      end
      if (lk <= ck) break;
      heap_val[i] = heap_val[c];
      heap_run[i] = heap_run[c];
      i = c;
    end
    heap_val[i] = lv;
    heap_run[i] = lr;
  endfunction

  // Apply one accepted beat; queue the merged result it produces, if any.
  function automatic void merge_predict(run_beat_t b);
    merge_res_t res;
    logic [31:0] pv;
    logic [6:0]  pr;
    int unsigned rc;
    rc = active_runs();
    if (fill_seen < rc) begin
      if (!b.ex) heap_push(b.value, b.run);
      fill_seen++;
      if (fill_seen < rc) return;  // still filling: no beat out
    end else if (!b.ex) begin
      heap_push(b.value, b.run);
    end
    if (heap_len == 0) begin
      res = '{min_value: '0, refill_run: '0, done_res: 1'b1};
      owed_valid = 0;
    end else begin
      heap_take(pv, pr);
      res = '{min_value: pv, refill_run: pr, done_res: 1'b0};
      owed_run = pr;
      owed_valid = 1;
    end
    pending_q.insert(pending_q.size(), res);
  endfunction

  // ------------------------------------------------------------------ sender
  // Hold valid high across back-to-back beats; lowering is left to idle_gap and drain_and_settle.
  task automatic send_beat(run_beat_t b);
    in_ch.valid     <= 1'b1;
    in_ch.value     <= b.value;
    in_ch.run_id    <= b.run;
    in_ch.exhausted <= b.ex;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    merge_predict(b);
    if (!b.ex) run_tail[b.run] = b.value;
    beats_sent++;
  endtask

  task automatic idle_gap(int unsigned n);
    if (n == 0) return;
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop offering beats until every expected result is back, then settle.
  task automatic drain_and_settle();
    int unsigned guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_runs(logic [7:0] v);
    drain_and_settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    runs_reg = v;
    owed_valid = 0;
  endtask

  // Well-formed beat: fill runs in order, then answer for the owed run with a
  // non-decreasing value. About one beat in seven is pure noise.
  function automatic run_beat_t next_beat();
    run_beat_t b;
    logic signed [32:0] sum;
    if ($urandom_range(0, 99) < 14) begin
      b.value = $urandom;
      b.run   = 7'($urandom_range(0, 127));
      b.ex    = $urandom_range(0, 3) == 0;
      return b;
    end
    if (fill_seen < active_runs()) begin
      b.run   = fill_seen[6:0];
      b.value = $signed($urandom_range(0, 4000)) - 2000;
      b.ex    = $urandom_range(0, 29) == 0;
    end else if (!owed_valid) begin
      // Merge is done: seed some run afresh, sometimes at a far value.
      b.run   = 7'($urandom_range(0, 127));
      b.value = ($urandom_range(0, 3) == 0) ? $urandom : $signed($urandom_range(0, 200));
      b.ex    = $urandom_range(0, 7) == 0;
    end else begin
      b.run = owed_run;
      sum   = run_tail[owed_run] + $signed({1'b0, $urandom_range(0, 40)});
      if (sum > 33'sh0_7FFF_FFFF) sum = 33'sh0_7FFF_FFFF;
      b.value = sum[31:0];
      b.ex    = $urandom_range(0, 19) == 0;
    end
    return b;
  endfunction

  // Bursts of random length separated by random gaps.
  task automatic send_random(int unsigned count);
    int unsigned burst_left;
    burst_left = 0;
    repeat (count) begin
      if (burst_left == 0) begin
        idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      send_beat(next_beat());
    end
  endtask

  // ---------------------------------------------------------------- receiver
  // Stall pattern is redrawn from rx_cycle: free-running, light or heavy.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 256 == 0) begin
      case ($urandom_range(0, 2))
        0: begin
          stall_pct <= 0;
        end
        1: begin
          stall_pct <= 30;
        end
        default: begin
          stall_pct <= 75;
        end
      endcase
    end
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_on && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    merge_res_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.done_res) dones_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: min=%0d run=%0d done=%0b", $realtime,
                   out_ch.min_value, out_ch.refill_run, out_ch.done_res);
      end else begin
        want = pending_q.pop_front();
        if (out_ch.min_value !== want.min_value || out_ch.refill_run !== want.refill_run ||
            out_ch.done_res !== want.done_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] mismatch: exp min=%0d run=%0d done=%0b, got min=%0d run=%0d done=%0b",
                     $realtime, want.min_value, want.refill_run, want.done_res,
                     out_ch.min_value, out_ch.refill_run, out_ch.done_res);
        end
      end
    end
  end

  // ------------------------------------------------------------------ tests
  // Extremes, ties on equal values, exhaustion during fill and merge, done
  // repeated after the heap empties, then a fresh run.
  task automatic test_directed();
    run_beat_t seq [13];
    seq[0]  = '{32'sh8000_0000, 7'd0, 1'b0};
    seq[1]  = '{32'sh7FFF_FFFF, 7'd1, 1'b0};
    seq[2]  = '{32'sh1234_5678, 7'd2, 1'b1};  // exhausted during fill
    seq[3]  = '{32'sd0,         7'd3, 1'b0};  // completes the fill, pops
    seq[4]  = '{32'sd0,         7'd0, 1'b0};  // ties with run 3
    seq[5]  = '{32'sh0,         7'd0, 1'b1};
    seq[6]  = '{32'sh7FFF_FFFF, 7'd3, 1'b0};  // ties with run 1 at max
    seq[7]  = '{32'sh0,         7'd1, 1'b1};
    seq[8]  = '{32'shFFFF_FFFF, 7'd3, 1'b1};  // heap empties: done
    seq[9]  = '{32'sh5555_5555, 7'd5, 1'b1};  // done again
    seq[10] = '{-32'sd1,        7'd127, 1'b0};
    seq[11] = '{-32'sd1,        7'd64, 1'b0};
    seq[12] = '{32'shAAAA_AAAA, 7'd42, 1'b1};
    load_runs(8'd4);
    foreach (seq[i]) send_beat(seq[i]);
    drain_and_settle();
  endtask

  // Run count of zero behaves as one; steady merge traffic.
  task automatic test_single_run();
    load_runs(8'd0);
    send_random(200);
  endtask

  // Largest count (above the heap size, clamped): refills up to 128 runs.
  task automatic test_wide_fill();
    load_runs(8'd255);
    send_random(520);
  endtask

  // Long receiver hold-off while the sender keeps offering beats.
  task automatic test_backpressure();
    fork
      begin
        hold_on <= 1'b1;
        repeat (600) @(posedge clk);
        hold_on <= 1'b0;
      end
      begin
        repeat (60) send_beat(next_beat());
      end
    join
    drain_and_settle();
  endtask

  task automatic test_rewrite_counts();
    load_runs(8'd128);
    send_random(250);
    load_runs(8'd1);
    send_random(250);
    load_runs(8'($urandom_range(2, 127)));
    send_random(250);
  endtask

  initial begin
    clk = 0;
    rst = 1;
    cfg_we = 0;
    cfg_wdata = '0;
    in_ch.valid = 0;
    in_ch.value = '0;
    in_ch.run_id = '0;
    in_ch.exhausted = 0;
    out_ch.ready = 0;
    hold_on = 0;
    stall_pct = 0;
    rx_cycle = 0;
    heap_len = 0;
    fill_seen = 0;
    runs_reg = 8'd1;
    owed_run = '0;
    owed_valid = 0;
    mismatches = 0;
    beats_sent = 0;
    results_seen = 0;
    dones_seen = 0;
    foreach (run_tail[i]) run_tail[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_single_run();
    test_wide_fill();
    test_backpressure();
    test_rewrite_counts();
    drain_and_settle();

    if (pending_q.size() != 0) begin
      mismatches += pending_q.size();
      $display("%0d expected results never arrived", pending_q.size());
    end
    $display("Sent %0d run beats over run counts 0,1,4,128,255 and one random count;",
             beats_sent);
    $display("checked %0d merged results (%0d done marks), %0d mismatches.",
             results_seen, dones_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #30ms;
    $display("Timeout with %0d results outstanding", pending_q.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
